// ===== hdl/asht_pkg.sv =====
// Shared types and constants of the access site hit table.
// Holds the channel payload structs, status codes, register indexes and the
// controller state and command types. No dependencies.
`timescale 1ns / 1ps

package asht_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int VADDR_W    = 48;
    localparam int CNT_BITS   = 32;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OWN_BASE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_END     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_END  = 4'd3;

    // Command codes of the input beat.
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Result status codes.
    localparam logic [2:0] STAT_OWN      = 3'd0;
    localparam logic [2:0] STAT_FOREIGN  = 3'd1;
    localparam logic [2:0] STAT_EXISTING = 3'd2;
    localparam logic [2:0] STAT_NEW      = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;
    localparam logic [2:0] STAT_READOUT  = 3'd5;

    typedef struct packed {
        logic                cmd;
        logic [VADDR_W-1:0]  instr_addr;
        logic [31:0]         thread_id;
        logic [5:0]          read_index;
    } hit_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] total_hits;
        logic [31:0] foreign_hits;
        logic [6:0]  site_count;
        logic [31:0] site_offset;
        logic [31:0] site_hits;
        logic [31:0] tid_first;
        logic [31:0] tid_second;
        logic [31:0] tid_third;
        logic [31:0] tid_fourth;
    } hit_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_SCAN,
        S_UPDATE,
        S_CLAIM,
        S_READ,
        S_DONE
    } asht_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       scan_start;
        logic       scan_en;
        logic       inc_total;
        logic       inc_foreign;
        logic       upd_write;
        logic       claim_write;
        logic       read_issue;
        logic       set_status;
        logic [2:0] status_code;
        logic       out_load;
    } asht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic own_hit;
        logic tgt_hit;
        logic scan_match;
        logic scan_done;
        logic table_full;
        logic out_free;
    } asht_flags_t;

endpackage

// ===== hdl/asht_ctrl.sv =====
// Controller state machine of the access site hit table.
// Sequences classify, table scan, update or claim, readout and result load.
// Depends on asht_pkg.
`timescale 1ns / 1ps

module asht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  asht_pkg::asht_flags_t flags,
    output asht_pkg::asht_cmd_t   cmd
);
    import asht_pkg::*;

    asht_state_t state_reg;
    asht_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (flags.is_read) begin
                    state_next = S_READ;
                end else if (flags.own_hit) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_OWN;
                    state_next      = S_DONE;
                end else if (!flags.tgt_hit) begin
                    cmd.inc_foreign = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_FOREIGN;
                    state_next      = S_DONE;
                end else begin
                    cmd.inc_total  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (flags.scan_match) begin
                    state_next = S_UPDATE;
                end else if (flags.scan_done) begin
                    if (flags.table_full) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_FULL;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_CLAIM;
                    end
                end
            end
            S_UPDATE: begin
                cmd.upd_write   = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = STAT_EXISTING;
                state_next      = S_DONE;
            end
            S_CLAIM: begin
                cmd.claim_write = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = STAT_NEW;
                state_next      = S_DONE;
            end
            S_READ: begin
                cmd.read_issue  = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = STAT_READOUT;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (flags.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/asht_datapath.sv =====
// Datapath of the access site hit table: range registers, counters, the site
// memory with its scan pointer, and the result register.
// Depends on asht_pkg; driven by asht_ctrl through command and status structs.
`timescale 1ns / 1ps

module asht_datapath #(
    parameter int SITE_ENTRIES = 64,
    parameter int THREAD_SLOTS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [asht_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asht_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  asht_pkg::hit_in_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output asht_pkg::hit_out_t                m_data,
    input  asht_pkg::asht_cmd_t               cmd,
    output asht_pkg::asht_flags_t             flags
);
    import asht_pkg::*;

    localparam int ADDR_W   = $clog2(SITE_ENTRIES);
    localparam int CNT_W    = $clog2(SITE_ENTRIES + 1);
    localparam int IDX_W    = CNT_W + 6;
    localparam int HITS_LSB = 32;
    localparam int TID_LSB  = 64;
    localparam int ROW_W    = 64 + 32 * THREAD_SLOTS;

    // Range registers.
    logic [VADDR_W-1:0] own_base_reg, own_end_reg, target_base_reg, target_end_reg;

    // Item and bookkeeping registers.
    hit_in_t            in_reg;
    logic [2:0]         status_reg;
    logic [31:0]        offset_reg;
    logic [31:0]        total_reg;
    logic [31:0]        foreign_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [ADDR_W-1:0]  cmp_idx_reg;
    logic               rvalid_reg;
    logic               read_hit_reg;

    // Site memory: offset, hit count and thread slots share one row.
    logic [ROW_W-1:0]   site_mem [SITE_ENTRIES];
    logic [ROW_W-1:0]   rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               m_valid_reg;
    hit_out_t           m_data_reg;
    hit_out_t           m_data_next;

    logic [VADDR_W-1:0] tgt_diff;
    logic               scan_issue;
    logic               scan_rd;
    logic               match_now;
    logic [IDX_W-1:0]   idx_wide;
    logic               read_hit;
    logic [31:0]        row_hits;
    logic [ROW_W-1:0]   upd_row;
    logic [ROW_W-1:0]   new_row;
    logic               slot_found;
    logic [31:0]        tid_view [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_base_reg    <= '0;
            own_end_reg     <= '0;
            target_base_reg <= '0;
            target_end_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OWN_BASE:    own_base_reg    <= cfg_data;
                REG_OWN_END:     own_end_reg     <= cfg_data;
                REG_TARGET_BASE: target_base_reg <= cfg_data;
                REG_TARGET_END:  target_end_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Range tests and offset of the held item.
    assign tgt_diff = in_reg.instr_addr - target_base_reg;

    assign scan_issue = scan_idx_reg < count_reg;
    assign match_now  = rvalid_reg && (rdata_reg[31:0] == offset_reg);
    assign scan_rd    = cmd.scan_en && scan_issue && !match_now;

    assign idx_wide = IDX_W'(in_reg.read_index);
    assign read_hit = idx_wide < IDX_W'(count_reg);

    assign flags.is_read    = in_reg.cmd == CMD_READ;
    assign flags.own_hit    = (in_reg.instr_addr >= own_base_reg) &&
                              (in_reg.instr_addr < own_end_reg);
    assign flags.tgt_hit    = (in_reg.instr_addr >= target_base_reg) &&
                              (in_reg.instr_addr < target_end_reg);
    assign flags.scan_match = match_now;
    assign flags.scan_done  = !scan_issue && !rvalid_reg;
    assign flags.table_full = count_reg == CNT_W'(SITE_ENTRIES);
    assign flags.out_free   = !m_valid_reg || m_ready;

    // Row rewrite on a hit: bump the count and place the thread in the first
    // slot that is empty or already holds it.
    assign row_hits = rdata_reg[HITS_LSB +: 32];

    always_comb begin
        upd_row    = rdata_reg;
        slot_found = 1'b0;
        upd_row[HITS_LSB +: 32] = (row_hits == CNT_MAX) ? row_hits : row_hits + 32'd1;
        for (int s = 0; s < THREAD_SLOTS; s++) begin
            if (!slot_found) begin
                if (rdata_reg[TID_LSB + 32 * s +: 32] == 32'd0) begin
                    upd_row[TID_LSB + 32 * s +: 32] = in_reg.thread_id;
                    slot_found = 1'b1;
                end else if (rdata_reg[TID_LSB + 32 * s +: 32] == in_reg.thread_id) begin
                    slot_found = 1'b1;
                end
            end
        end
    end

    always_comb begin
        new_row                 = '0;
        new_row[31:0]           = offset_reg;
        new_row[HITS_LSB +: 32] = 32'd1;
        new_row[TID_LSB +: 32]  = in_reg.thread_id;
    end

    always_comb begin
        mem_we    = cmd.upd_write || cmd.claim_write;
        mem_waddr = cmd.upd_write ? cmp_idx_reg : count_reg[ADDR_W-1:0];
        mem_wdata = cmd.upd_write ? upd_row : new_row;
        mem_re    = scan_rd || (cmd.read_issue && read_hit);
        mem_raddr = scan_rd ? scan_idx_reg[ADDR_W-1:0] : idx_wide[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            site_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= site_mem[mem_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.scan_start) begin
            offset_reg <= tgt_diff[31:0];
        end
        if (scan_rd) begin
            cmp_idx_reg <= scan_idx_reg[ADDR_W-1:0];
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status_code;
        end
        if (cmd.out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    // Control state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            foreign_reg  <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rvalid_reg   <= 1'b0;
            read_hit_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.inc_total && total_reg != CNT_MAX) begin
                total_reg <= total_reg + 32'd1;
            end
            if (cmd.inc_foreign && foreign_reg != CNT_MAX) begin
                foreign_reg <= foreign_reg + 32'd1;
            end
            if (cmd.claim_write) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
            end else if (scan_rd) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            rvalid_reg <= scan_rd;
            if (cmd.load_in) begin
                read_hit_reg <= 1'b0;
            end else if (cmd.read_issue) begin
                read_hit_reg <= read_hit;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Readout view of the first four thread slots.
    for (genvar g = 0; g < 4; g++) begin : g_tid
        if (g < THREAD_SLOTS) begin : g_on
            assign tid_view[g] = rdata_reg[TID_LSB + 32 * g +: 32];
        end else begin : g_off
            assign tid_view[g] = 32'd0;
        end
    end

    always_comb begin
        m_data_next              = '0;
        m_data_next.status       = status_reg;
        m_data_next.total_hits   = total_reg;
        m_data_next.foreign_hits = foreign_reg;
        m_data_next.site_count   = 7'(count_reg);
        if (in_reg.cmd == CMD_READ && read_hit_reg) begin
            m_data_next.site_offset = rdata_reg[31:0];
            m_data_next.site_hits   = rdata_reg[HITS_LSB +: 32];
            m_data_next.tid_first   = tid_view[0];
            m_data_next.tid_second  = tid_view[1];
            m_data_next.tid_third   = tid_view[2];
            m_data_next.tid_fourth  = tid_view[3];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/access_site_hit_table_unit.sv =====
// Top level of the access site hit table: controller plus datapath.
// Depends on asht_pkg, asht_ctrl and asht_datapath.
`timescale 1ns / 1ps

// The block profiles watched-memory accesses by instruction site. Each input
// beat on the s_ channel is either a hit record (instruction address and thread
// id) or a readout request for one site entry. Every input beat yields exactly
// one result beat on the m_ channel with a status code, the hit counters, the
// number of claimed sites and, for a readout, the entry contents.
// The four range registers are written through the cfg_ channel, which is
// ready whenever reset is released; write them only while no item is in flight.
// Sequence: a hit in the own range or a foreign hit passes the classify state,
// then the done state that loads the result register; a readout passes a read
// state between the two. A hit inside the target range walks the site memory
// one entry per cycle over its single read port, then passes an update or claim
// state before the done state; a full table goes from the scan straight to the
// done state.
// One item is processed at a time; the next beat is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls with a result pending, the block holds the next
// result until the output register frees up.
// Synchronous reset clears the counters, the claimed count and the range
// registers; site memory contents are not cleared and need no clearing pass.
module access_site_hit_table_unit #(
    parameter int SITE_ENTRIES = 64,
    parameter int THREAD_SLOTS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [asht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [asht_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  asht_pkg::hit_in_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output asht_pkg::hit_out_t              m_data
);
    import asht_pkg::*;

    asht_cmd_t   cmd;
    asht_flags_t flags;

    // Range registers accept a write in every cycle out of reset.
    assign cfg_ready = aresetn;

    // The controller owns sequencing; the datapath owns all storage.
    asht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    asht_datapath #(
        .SITE_ENTRIES (SITE_ENTRIES),
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .flags     (flags)
    );

`ifndef SYNTHESIS
    // At most one of the exclusive datapath actions fires in a cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_in, cmd.upd_write, cmd.claim_write, cmd.read_issue,
                  cmd.out_load}))
        else $error("conflicting datapath commands");

    // A full-table result reports the table as completely claimed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_FULL) |->
            (m_data.site_count == 7'(SITE_ENTRIES)))
        else $error("table full reported below capacity");

    // Record results never carry readout data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_READOUT) |->
            (m_data.site_hits == 32'd0 && m_data.site_offset == 32'd0 &&
             m_data.tid_first == 32'd0))
        else $error("readout fields set on a record result");

    // A fresh item is only taken while no update is pending on the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> !cmd.upd_write && !cmd.claim_write)
        else $error("table write right after item accept");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the access site hit table unit.
// Depends on asht_pkg and access_site_hit_table_unit; drives hit and readout beats
// and checks every result beat against a profile model kept inside the testbench.
`timescale 1ns / 1ps

// The run has a directed part and a random part. The directed part is a table of
// beats and range settings walked in order. It covers the own, foreign, new-site,
// existing-site and readout outcomes, the range edges, overlapping and empty
// ranges, offsets that alias modulo 4 GiB, a zero thread id and a site whose four
// thread slots are all taken. A few rows carry a typed-in result that is obvious
// from the settings. All other rows, and every random beat, are checked against
// the profile model below, which keeps its own copy of the site table, the
// counters and the range registers.
// The random part runs in five phases, each with its own range setting and its
// own idling pattern. Only 64 sites can ever be claimed, and reset is applied
// once, so random hits land on a pool of 90 offsets: the table fills up early
// and every later new offset reports a full table.
module testbench;
    import asht_pkg::*;

    localparam int N_SITES = 64;
    localparam int N_SLOTS = 4;
    localparam logic [VADDR_W-1:0] ADDR_TOP = '1;
    // Random hits in the target range use offsets k * SITE_STRIDE, k < SITE_POOL.
    localparam int SITE_POOL = 90;
    localparam logic [VADDR_W-1:0] SITE_STRIDE = 48'h38;
    localparam int PHASE_ITEMS = 375;
    // Length of the long receiver hold-off in the back-pressure phase.
    localparam int HOLD_CYCLES = 400;
    // A hit walks at most 64 sites, and the longest stall is the hold-off, so
    // this many cycles with no beat at all means a hang.
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 80;
    localparam int REPORT_MAX = 10;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    hit_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    hit_out_t              m_data;

    access_site_hit_table_unit #(
        .SITE_ENTRIES(N_SITES),
        .THREAD_SLOTS(N_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Profile model state: range registers, site table and counters.
    logic [VADDR_W-1:0] own_lo = '0;
    logic [VADDR_W-1:0] own_hi = '0;
    logic [VADDR_W-1:0] tgt_lo = '0;
    logic [VADDR_W-1:0] tgt_hi = '0;
    logic [31:0]        site_off [N_SITES];
    logic [31:0]        site_hit_cnt [N_SITES];
    logic [31:0]        site_tid [N_SITES][N_SLOTS];
    int unsigned        claimed = 0;
    logic [31:0]        inside_total = '0;
    logic [31:0]        outside_total = '0;

    // Results still owed by the block, oldest first.
    hit_out_t pending_results [$];

    int          mismatches = 0;
    int          quiet = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        hold_go = 1'b0;
    int          held = 0;
    // Mirrors s_valid as last assigned, so that it is lowered once per gap.
    bit          offering = 1'b0;

    // One row of the directed table: either a full range setting or one beat.
    typedef struct {
        bit                            sets_ranges;
        logic [3:0][VADDR_W-1:0]       ranges;
        hit_in_t                       beat;
        bit                            has_known;
        hit_out_t                      known;
    } plan_row_t;

    plan_row_t plan [$];

    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // Applies one beat to the profile model and returns the result it must give.
    function automatic hit_out_t tally_access(input hit_in_t b);
        hit_out_t    r;
        logic [31:0] off;
        int          found;
        int          i;
        int          s;
        r = '0;
        found = -1;
        if (b.cmd == CMD_READ) begin
            r.status = STAT_READOUT;
            // An unclaimed entry reads back as all zeros.
            if (b.read_index < claimed) begin
                r.site_offset = site_off[b.read_index];
                r.site_hits   = site_hit_cnt[b.read_index];
                r.tid_first   = site_tid[b.read_index][0];
                r.tid_second  = site_tid[b.read_index][1];
                r.tid_third   = site_tid[b.read_index][2];
                r.tid_fourth  = site_tid[b.read_index][3];
            end
        end else if (b.instr_addr >= own_lo && b.instr_addr < own_hi) begin
            // The own range is tested first, so it wins where the ranges overlap.
            r.status = STAT_OWN;
        end else if (b.instr_addr < tgt_lo || b.instr_addr >= tgt_hi) begin
            r.status = STAT_FOREIGN;
            outside_total = sat_bump(outside_total);
        end else begin
            inside_total = sat_bump(inside_total);
            // Only the low 32 bits of the offset name a site.
            off = b.instr_addr[31:0] - tgt_lo[31:0];
            for (i = 0; i < claimed; i++) begin
                if (found < 0 && site_off[i] == off)
                    found = i;
            end
            if (found >= 0) begin
                r.status = STAT_EXISTING;
                site_hit_cnt[found] = sat_bump(site_hit_cnt[found]);
                // First slot that is empty or already holds the thread; when all
                // slots hold other threads the thread is dropped.
                for (s = 0; s < N_SLOTS; s++) begin
                    if (site_tid[found][s] == '0) begin
                        site_tid[found][s] = b.thread_id;
                        break;
                    end
                    if (site_tid[found][s] == b.thread_id)
                        break;
                end
            end else if (claimed >= N_SITES) begin
                r.status = STAT_FULL;
            end else begin
                r.status = STAT_NEW;
                site_off[claimed] = off;
                site_hit_cnt[claimed] = 32'd1;
                for (s = 0; s < N_SLOTS; s++)
                    site_tid[claimed][s] = '0;
                site_tid[claimed][0] = b.thread_id;
                claimed++;
            end
        end
        r.total_hits   = inside_total;
        r.foreign_hits = outside_total;
        r.site_count   = 7'(claimed);
        return r;
    endfunction

    function automatic bit same_result(input hit_out_t e, input hit_out_t a);
        return a.status === e.status && a.total_hits === e.total_hits
            && a.foreign_hits === e.foreign_hits && a.site_count === e.site_count
            && a.site_offset === e.site_offset && a.site_hits === e.site_hits
            && a.tid_first === e.tid_first && a.tid_second === e.tid_second
            && a.tid_third === e.tid_third && a.tid_fourth === e.tid_fourth;
    endfunction

    task automatic show_result(input string tag, input hit_out_t v);
        $display("  %s status=%0d total=%0d foreign=%0d sites=%0d offset=%h hits=%0d tids=%h %h %h %h",
                 tag, v.status, v.total_hits, v.foreign_hits, v.site_count, v.site_offset,
                 v.site_hits, v.tid_first, v.tid_second, v.tid_third, v.tid_fourth);
    endtask

    // Helpers that build beats and obvious results for the directed table.
    function automatic hit_in_t rec(input logic [VADDR_W-1:0] addr, input logic [31:0] tid);
        hit_in_t b;
        b = '0;
        b.cmd = CMD_RECORD;
        b.instr_addr = addr;
        b.thread_id = tid;
        return b;
    endfunction

    function automatic hit_in_t rd(input logic [5:0] idx);
        hit_in_t b;
        b = '0;
        b.cmd = CMD_READ;
        b.read_index = idx;
        return b;
    endfunction

    function automatic hit_out_t bare(input logic [2:0] st, input logic [31:0] tot,
                                      input logic [31:0] fgn, input logic [6:0] cnt);
        hit_out_t r;
        r = '0;
        r.status = st;
        r.total_hits = tot;
        r.foreign_hits = fgn;
        r.site_count = cnt;
        return r;
    endfunction

    task automatic add_beat(input hit_in_t b);
        plan_row_t row;
        row.sets_ranges = 1'b0;
        row.ranges = '0;
        row.beat = b;
        row.has_known = 1'b0;
        row.known = '0;
        plan.push_back(row);
    endtask

    task automatic add_known(input hit_in_t b, input hit_out_t k);
        plan_row_t row;
        row.sets_ranges = 1'b0;
        row.ranges = '0;
        row.beat = b;
        row.has_known = 1'b1;
        row.known = k;
        plan.push_back(row);
    endtask

    task automatic add_ranges(input logic [VADDR_W-1:0] ob, oe, tb, te);
        plan_row_t row;
        row.sets_ranges = 1'b1;
        row.ranges[REG_OWN_BASE] = ob;
        row.ranges[REG_OWN_END] = oe;
        row.ranges[REG_TARGET_BASE] = tb;
        row.ranges[REG_TARGET_END] = te;
        row.beat = '0;
        row.has_known = 1'b0;
        row.known = '0;
        plan.push_back(row);
    endtask

    // Random address in [lo, hi); callers make sure the span is not empty.
    function automatic logic [VADDR_W-1:0] in_span(input logic [VADDR_W-1:0] lo, hi);
        logic [63:0] w;
        w = {$urandom, $urandom};
        return lo + VADDR_W'(w % 64'(hi - lo));
    endfunction

    // A few thread ids recur so that slots fill up; the rest are fully random.
    function automatic logic [31:0] pick_thread();
        int unsigned r;
        logic [31:0] t;
        r = $urandom_range(9);
        t = $urandom;
        case (r)
            0: t = 32'd1;
            1: t = 32'd2;
            2: t = 32'd3;
            3: t = 32'hFFFF_FFFF;
            4: t = 32'h8000_0000;
            5: t = 32'h0000_BEEF;
            default: begin
                if (t == '0)
                    t = 32'd1;
            end
        endcase
        return t;
    endfunction

    // Random beat shaped by the current ranges: mostly hits on the site pool,
    // with readouts, own hits, foreign hits and unshaped addresses mixed in.
    function automatic hit_in_t pick_beat();
        hit_in_t            b;
        int unsigned        roll;
        logic [VADDR_W-1:0] site;
        logic [63:0]        far;
        b.cmd = CMD_RECORD;
        b.instr_addr = in_span('0, ADDR_TOP);
        b.thread_id = pick_thread();
        b.read_index = 6'($urandom_range(63));
        roll = $urandom_range(99);
        if (roll < 12) begin
            b.cmd = CMD_READ;
            if (claimed != 0 && roll < 9)
                b.read_index = 6'($urandom_range(claimed - 1));
        end else if (roll < 22) begin
            if (own_lo < own_hi)
                b.instr_addr = in_span(own_lo, own_hi);
        end else if (roll < 34) begin
            if (tgt_lo != '0 && (roll[0] || tgt_hi == ADDR_TOP))
                b.instr_addr = in_span('0, tgt_lo);
            else if (tgt_hi != ADDR_TOP)
                b.instr_addr = in_span(tgt_hi, ADDR_TOP);
            else
                b.instr_addr = ADDR_TOP;
        end else if (roll < 92) begin
            site = VADDR_W'($urandom_range(SITE_POOL - 1)) * SITE_STRIDE;
            if (tgt_lo < tgt_hi && site < tgt_hi - tgt_lo) begin
                // In a wide target range, the same site may be hit a multiple of 4 GiB higher.
                far = 64'(tgt_lo) + 64'(site) + (64'($urandom_range(3)) << 32);
                b.instr_addr = (roll[0] && far < 64'(tgt_hi)) ? far[VADDR_W-1:0]
                                                              : tgt_lo + site;
            end
        end
        return b;
    endfunction

    task automatic lower_valid();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offers one beat, waits for it to be taken, and queues the result it owes.
    task automatic offer_beat(input hit_in_t b, input bit has_known, input hit_out_t known);
        hit_out_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            lower_valid();
            @(posedge aclk);
        end
        s_data <= b;
        s_valid <= 1'b1;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        want = tally_access(b);
        pending_results.push_back(has_known ? known : want);
    endtask

    // Every beat yields one result, so the block is idle once none is owed.
    task automatic drain_results();
        lower_valid();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no dead cycle.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VADDR_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_ranges(input logic [VADDR_W-1:0] ob, oe, tb, te);
        drain_results();
        put_reg(REG_OWN_BASE, ob);
        put_reg(REG_OWN_END, oe);
        put_reg(REG_TARGET_BASE, tb);
        put_reg(REG_TARGET_END, te);
        cfg_valid <= 1'b0;
        own_lo = ob;
        own_hi = oe;
        tgt_lo = tb;
        tgt_hi = te;
    endtask

    task automatic run_phase(input int unsigned idle, stall, input bit hold,
                             input logic [VADDR_W-1:0] ob, oe, tb, te);
        int n;
        load_ranges(ob, oe, tb, te);
        send_idle_pct = idle;
        stall_pct = stall;
        if (hold)
            hold_go <= 1'b1;
        for (n = 0; n < PHASE_ITEMS; n++)
            offer_beat(pick_beat(), 1'b0, '0);
        if (hold) begin
            drain_results();
            hold_go <= 1'b0;
        end
    endtask

    task automatic build_plan();
        // Right after reset all ranges are empty, so every hit is foreign.
        add_known(rd(6'd0), bare(STAT_READOUT, 32'd0, 32'd0, 7'd0));
        add_known(rec('0, 32'd1), bare(STAT_FOREIGN, 32'd0, 32'd1, 7'd0));
        add_known(rec(ADDR_TOP, 32'hFFFF_FFFF), bare(STAT_FOREIGN, 32'd0, 32'd2, 7'd0));

        // Disjoint own and target ranges; probe both edges of each.
        add_ranges(48'h1000, 48'h2000, 48'h10_0000, 48'h20_0000);
        add_known(rec(48'h1000, 32'd5), bare(STAT_OWN, 32'd0, 32'd2, 7'd0));
        add_beat(rec(48'h1FFF, 32'd5));
        add_beat(rec(48'h0F_FFFF, 32'd5));
        add_beat(rec(48'h20_0000, 32'd5));
        add_beat(rec(48'h10_0000, 32'd1));
        add_beat(rec(48'h1F_FFFF, 32'd2));
        // Fill the thread slots of site 0, with a zero id that leaves its slot
        // looking empty, then one thread too many.
        add_beat(rec(48'h10_0000, 32'd2));
        add_beat(rec(48'h10_0000, 32'd1));
        add_beat(rec(48'h10_0000, 32'd0));
        add_beat(rec(48'h10_0000, 32'd3));
        add_beat(rec(48'h10_0000, 32'd4));
        add_beat(rec(48'h10_0000, 32'hFFFF_FFFF));
        add_beat(rd(6'd0));
        add_beat(rd(6'd1));
        add_beat(rd(6'd63));

        // Own range inside the target range: the own test wins.
        add_ranges(48'h10_0000, 48'h10_0100, 48'h10_0000, 48'h20_0000);
        add_beat(rec(48'h10_0000, 32'd9));

        // Empty own range (base above end) and the widest target range; offsets
        // 4 GiB apart name the same site.
        add_ranges(ADDR_TOP, '0, '0, ADDR_TOP);
        add_beat(rec(48'h10_0000, 32'd6));
        add_beat(rec(48'h1_0010_0000, 32'd7));
        add_beat(rec(ADDR_TOP - 48'd1, 32'd8));
        add_beat(rec(ADDR_TOP, 32'd8));
        add_beat(rd(6'd2));
        add_beat(rd(6'd3));
    endtask

    // Receiver: random stalls, plus one long hold-off counted here while
    // hold_go is set, so that the block fills up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go && held < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            held <= held + 1;
        end else begin
            if (!hold_go)
                held <= 0;
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: every result beat is matched against the oldest one owed.
    always @(posedge aclk) begin
        hit_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[%0t] result beat with no item outstanding", $time);
                    show_result("actual  ", m_data);
                end
            end else begin
                want = pending_results.pop_front();
                if (!same_result(want, m_data)) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("[%0t] result beat differs from the profile model", $time);
                        show_result("expected", want);
                        show_result("actual  ", m_data);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        build_plan();
        foreach (plan[p]) begin
            if (plan[p].sets_ranges)
                load_ranges(plan[p].ranges[REG_OWN_BASE], plan[p].ranges[REG_OWN_END],
                            plan[p].ranges[REG_TARGET_BASE], plan[p].ranges[REG_TARGET_END]);
            else
                offer_beat(plan[p].beat, plan[p].has_known, plan[p].known);
        end

        // Random phases: sender idle %, receiver stall %, hold-off, then ranges.
        run_phase(0, 0, 1'b0, 48'h0000_4000_0000, 48'h0000_4000_1000,
                  48'h0000_1000_0000, 48'h0000_1010_0000);
        run_phase(61, 0, 1'b0, ADDR_TOP, '0, '0, ADDR_TOP);
        run_phase(0, 61, 1'b0, 48'hFFFF_0000_0000, 48'hFFFF_0000_0400,
                  48'hFFFF_0000_0000, ADDR_TOP);
        run_phase(24, 24, 1'b0, '0, 48'h100, 48'h1000, 48'h8_0000);
        run_phase(0, 0, 1'b1, 48'h7000, 48'h8000, 48'h2000_0000, 48'h2000_4000);

        // Let every owed result arrive, then watch a while for stray beats.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
